@@ src/mbw_pkg.sv @@
// Shared types, constants and helpers for the maze backtrack walker.
package mbw_pkg;

    localparam int GRID_ROWS   = 16;
    localparam int GRID_COLS   = 16;
    localparam int STACK_DEPTH = 256;

    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int CELL_AW    = $clog2(GRID_CELLS);
    localparam int STACK_AW   = $clog2(STACK_DEPTH);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int COORD_W    = 4;
    localparam int CELL_W     = 2;
    localparam int STAT_W     = 3;
    localparam int CNT_W      = 3;
    localparam int POS_W      = 2 * COORD_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Grid codes; the load kind uses the same encoding
    localparam logic [CELL_W-1:0] CELL_WALL = 2'd0;
    localparam logic [CELL_W-1:0] CELL_OPEN = 2'd1;
    localparam logic [CELL_W-1:0] CELL_SEEN = 2'd2;
    localparam logic [CELL_W-1:0] CELL_END  = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_LOADED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MOVED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BACK    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_AT_END  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NO_PATH = 3'd4;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CELL_W-1:0]  cell_kind;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] pos_row;
        logic [COORD_W-1:0] pos_col;
        logic [STAT_W-1:0]  status;
        logic [CNT_W-1:0]   branch_count;
        logic               pushed;
    } t_out_item;

    function automatic logic in_grid(input logic [COORD_W-1:0] row,
                                     input logic [COORD_W-1:0] col);
        return (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                     input logic [COORD_W-1:0] col);
        return CELL_AW'(int'(row) * GRID_COLS + int'(col));
    endfunction

    function automatic logic passable(input logic [CELL_W-1:0] code);
        return (code == CELL_OPEN) || (code == CELL_END);
    endfunction

endpackage

@@ src/mbw_ram.sv @@
// Generic single-port RAM with registered read.
module mbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/maze_backtrack_walker_top.sv @@
// Depth-first maze walker: grid memory, branch-point stack memory and step sequencer.
//
//  channel | handshake              | payload               | notes
//  --------+------------------------+-----------------------+---------------------------
//  input   | start (accept: !busy)  | i_item  (t_in_item)   | load one cell or one step
//  result  | o_valid (1-cycle pulse)| o_result (t_out_item) | one result per item
//
// A load item is taken in idle; busy stays low and its result pulses the
// next cycle. A step item reads the current cell and its four neighbors through
// the single grid memory port, one cell per cycle, so busy is high through the
// down, up, right, left and decide states; a backtrack adds the pop state for
// the stack memory read. A step that finds the walker already at the end
// returns from the down state.
// Reset: i_rst_n is synchronous, active low. Every grid cell reads as wall after
// reset through per-cell valid bits; the stack memory needs no clearing.
// Stalls: the receiver cannot stall; each result is shown for exactly one cycle.
module maze_backtrack_walker_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  mbw_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_valid,
    output mbw_pkg::t_out_item o_result
);

    // Sequencer states: each neighbor state names the neighbor read issued in it
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DN   = 3'd1;  // cur cell data back, issue down
    localparam logic [2:0] ST_UP   = 3'd2;  // down back, issue up
    localparam logic [2:0] ST_RT   = 3'd3;  // up back, issue right
    localparam logic [2:0] ST_LT   = 3'd4;  // right back, issue left
    localparam logic [2:0] ST_DEC  = 3'd5;  // left back, decide and write back
    localparam logic [2:0] ST_POP  = 3'd6;  // stack data back, jump

    logic [2:0] r_state, n_state;

    // Walker and bookkeeping
    logic [mbw_pkg::COORD_W-1:0] r_row, n_row, r_col, n_col;
    logic [1:0]                  r_came, n_came;
    logic                        r_started, n_started;
    logic [mbw_pkg::COORD_W-1:0] r_st_row, n_st_row, r_st_col, n_st_col;
    logic [mbw_pkg::COORD_W-1:0] r_end_row, n_end_row, r_end_col, n_end_col;
    logic [mbw_pkg::SP_W-1:0]    r_sp, n_sp;
    logic [mbw_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    // Captured neighbor codes
    logic [mbw_pkg::CELL_W-1:0] r_code_dn, n_code_dn;
    logic [mbw_pkg::CELL_W-1:0] r_code_up, n_code_up;
    logic [mbw_pkg::CELL_W-1:0] r_code_rt, n_code_rt;

    // Grid memory port and per-cell written flags (unwritten reads as wall)
    logic                         g_we;
    logic [mbw_pkg::CELL_AW-1:0]  g_addr;
    logic [mbw_pkg::CELL_W-1:0]   g_wdata, g_rdata;
    logic                         g_rd_ok;
    logic                         r_rd_ok;
    logic [mbw_pkg::GRID_CELLS-1:0] r_grid_vld;
    logic [mbw_pkg::CELL_W-1:0]   code_now;

    // Stack memory port
    logic                          s_we;
    logic [mbw_pkg::STACK_AW-1:0]  s_addr;
    logic [mbw_pkg::POS_W-1:0]     s_wdata, s_rdata;

    // Result register
    logic               r_out_valid, n_out_valid;
    mbw_pkg::t_out_item r_out, n_out;

    // Neighbor coordinates and in-grid flags
    logic [mbw_pkg::COORD_W-1:0] row_dn, row_up, col_rt, col_lt;
    logic                        ok_dn, ok_up, ok_rt, ok_lt;
    logic                        take_in;

    // Decision terms
    logic                        av_dn, av_up, av_rt, av_lt;
    logic [mbw_pkg::CNT_W-1:0]   cnt;
    logic                        do_push, moved, land_end;
    logic [mbw_pkg::COORD_W-1:0] mv_row, mv_col;
    logic [1:0]                  mv_came;
    logic [mbw_pkg::CELL_W-1:0]  mv_code;
    logic [mbw_pkg::SP_W-1:0]    sp_dec;

    mbw_ram #(
        .WIDTH(mbw_pkg::CELL_W),
        .DEPTH(mbw_pkg::GRID_CELLS)
    ) u_grid_ram (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_addr (g_addr),
        .i_wdata(g_wdata),
        .o_rdata(g_rdata)
    );

    mbw_ram #(
        .WIDTH(mbw_pkg::POS_W),
        .DEPTH(mbw_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_addr (s_addr),
        .i_wdata(s_wdata),
        .o_rdata(s_rdata)
    );

    assign take_in  = start && (r_state == ST_IDLE);
    assign code_now = r_rd_ok ? g_rdata : mbw_pkg::CELL_WALL;

    assign row_dn = r_row + 1'b1;
    assign row_up = r_row - 1'b1;
    assign col_rt = r_col + 1'b1;
    assign col_lt = r_col - 1'b1;
    assign ok_dn  = (r_row != '1) && mbw_pkg::in_grid(row_dn, r_col);
    assign ok_up  = (r_row != '0) && mbw_pkg::in_grid(row_up, r_col);
    assign ok_rt  = (r_col != '1) && mbw_pkg::in_grid(r_row, col_rt);
    assign ok_lt  = (r_col != '0) && mbw_pkg::in_grid(r_row, col_lt);

    // Step decision, valid in ST_DEC where code_now is the left neighbor
    assign av_dn  = mbw_pkg::passable(r_code_dn);
    assign av_up  = mbw_pkg::passable(r_code_up);
    assign av_rt  = mbw_pkg::passable(r_code_rt);
    assign av_lt  = mbw_pkg::passable(code_now);
    assign cnt    = mbw_pkg::CNT_W'(av_dn) + mbw_pkg::CNT_W'(av_up)
                  + mbw_pkg::CNT_W'(av_rt) + mbw_pkg::CNT_W'(av_lt);
    assign do_push = (cnt > mbw_pkg::CNT_W'(1))
                  && (r_sp < mbw_pkg::SP_W'(mbw_pkg::STACK_DEPTH));
    assign sp_dec  = r_sp - 1'b1;

    // Move priority: down, up, right, left, never back the way we came
    always_comb begin
        moved   = 1'b1;
        mv_row  = r_row;
        mv_col  = r_col;
        mv_came = r_came;
        mv_code = mbw_pkg::CELL_WALL;
        priority if (av_dn && r_came != mbw_pkg::DIR_DOWN) begin
            mv_row  = row_dn;
            mv_came = mbw_pkg::DIR_UP;
            mv_code = r_code_dn;
        end else if (av_up && r_came != mbw_pkg::DIR_UP) begin
            mv_row  = row_up;
            mv_came = mbw_pkg::DIR_DOWN;
            mv_code = r_code_up;
        end else if (av_rt && r_came != mbw_pkg::DIR_RIGHT) begin
            mv_col  = col_rt;
            mv_came = mbw_pkg::DIR_LEFT;
            mv_code = r_code_rt;
        end else if (av_lt && r_came != mbw_pkg::DIR_LEFT) begin
            mv_col  = col_lt;
            mv_came = mbw_pkg::DIR_RIGHT;
            mv_code = code_now;
        end else begin
            moved = 1'b0;
        end
    end

    assign land_end = ((mv_row == r_end_row) && (mv_col == r_end_col))
                   || (mv_code == mbw_pkg::CELL_END);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_came      = r_came;
        n_started   = r_started;
        n_st_row    = r_st_row;
        n_st_col    = r_st_col;
        n_end_row   = r_end_row;
        n_end_col   = r_end_col;
        n_sp        = r_sp;
        n_cnt       = r_cnt;
        n_code_dn   = r_code_dn;
        n_code_up   = r_code_up;
        n_code_rt   = r_code_rt;
        n_out_valid = 1'b0;
        n_out       = r_out;

        g_we    = 1'b0;
        g_addr  = mbw_pkg::cell_addr(r_row, r_col);
        g_wdata = mbw_pkg::CELL_SEEN;
        g_rd_ok = 1'b0;
        s_we    = 1'b0;
        s_addr  = r_sp[mbw_pkg::STACK_AW-1:0];
        s_wdata = {r_row, r_col};

        unique case (r_state)
            ST_IDLE: begin
                if (take_in && i_item.op == mbw_pkg::OP_LOAD) begin
                    g_addr  = mbw_pkg::cell_addr(i_item.row, i_item.col);
                    g_wdata = i_item.cell_kind;
                    if (mbw_pkg::in_grid(i_item.row, i_item.col)) begin
                        g_we = 1'b1;
                        if (i_item.cell_kind == mbw_pkg::CELL_SEEN) begin
                            n_st_row = i_item.row;
                            n_st_col = i_item.col;
                        end else if (i_item.cell_kind == mbw_pkg::CELL_END) begin
                            n_end_row = i_item.row;
                            n_end_col = i_item.col;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_out = '{pos_row: r_row, pos_col: r_col,
                              status: mbw_pkg::STAT_LOADED,
                              branch_count: '0, pushed: 1'b0};
                end else if (take_in) begin
                    // First step places the walker on the start cell
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_row     = r_st_row;
                        n_col     = r_st_col;
                        n_came    = mbw_pkg::DIR_LEFT;
                        g_addr    = mbw_pkg::cell_addr(r_st_row, r_st_col);
                        g_rd_ok   = mbw_pkg::in_grid(r_st_row, r_st_col);
                    end else begin
                        g_rd_ok   = mbw_pkg::in_grid(r_row, r_col);
                    end
                    n_state = ST_DN;
                end
            end
            ST_DN: begin
                if (((r_row == r_end_row) && (r_col == r_end_col))
                    || (code_now == mbw_pkg::CELL_END)) begin
                    n_out_valid = 1'b1;
                    n_out = '{pos_row: r_row, pos_col: r_col,
                              status: mbw_pkg::STAT_AT_END,
                              branch_count: '0, pushed: 1'b0};
                    n_state = ST_IDLE;
                end else begin
                    g_addr  = mbw_pkg::cell_addr(row_dn, r_col);
                    g_rd_ok = ok_dn;
                    n_state = ST_UP;
                end
            end
            ST_UP: begin
                n_code_dn = code_now;
                g_addr    = mbw_pkg::cell_addr(row_up, r_col);
                g_rd_ok   = ok_up;
                n_state   = ST_RT;
            end
            ST_RT: begin
                n_code_up = code_now;
                g_addr    = mbw_pkg::cell_addr(r_row, col_rt);
                g_rd_ok   = ok_rt;
                n_state   = ST_LT;
            end
            ST_LT: begin
                n_code_rt = code_now;
                g_addr    = mbw_pkg::cell_addr(r_row, col_lt);
                g_rd_ok   = ok_lt;
                n_state   = ST_DEC;
            end
            ST_DEC: begin
                // mark current cell visited
                g_we  = mbw_pkg::in_grid(r_row, r_col);
                n_cnt = cnt;
                n_state = ST_IDLE;
                if (moved) begin
                    s_we   = do_push;
                    n_sp   = r_sp + mbw_pkg::SP_W'(do_push);
                    n_row  = mv_row;
                    n_col  = mv_col;
                    n_came = mv_came;
                    n_out_valid = 1'b1;
                    n_out = '{pos_row: mv_row, pos_col: mv_col,
                              status: land_end ? mbw_pkg::STAT_AT_END
                                               : mbw_pkg::STAT_MOVED,
                              branch_count: cnt, pushed: do_push};
                end else if (do_push) begin
                    // push then pop of the same cell: walker stays put
                    n_out_valid = 1'b1;
                    n_out = '{pos_row: r_row, pos_col: r_col,
                              status: mbw_pkg::STAT_BACK,
                              branch_count: cnt, pushed: 1'b1};
                end else if (r_sp == '0) begin
                    n_out_valid = 1'b1;
                    n_out = '{pos_row: r_row, pos_col: r_col,
                              status: mbw_pkg::STAT_NO_PATH,
                              branch_count: cnt, pushed: 1'b0};
                end else begin
                    s_addr  = sp_dec[mbw_pkg::STACK_AW-1:0];
                    n_sp    = sp_dec;
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_row = s_rdata[mbw_pkg::POS_W-1:mbw_pkg::COORD_W];
                n_col = s_rdata[mbw_pkg::COORD_W-1:0];
                n_out_valid = 1'b1;
                n_out = '{pos_row: s_rdata[mbw_pkg::POS_W-1:mbw_pkg::COORD_W],
                          pos_col: s_rdata[mbw_pkg::COORD_W-1:0],
                          status: mbw_pkg::STAT_BACK,
                          branch_count: r_cnt, pushed: 1'b0};
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_came      <= mbw_pkg::DIR_LEFT;
            r_started   <= 1'b0;
            r_st_row    <= '0;
            r_st_col    <= '0;
            r_end_row   <= '0;
            r_end_col   <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
            r_grid_vld  <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_came      <= n_came;
            r_started   <= n_started;
            r_st_row    <= n_st_row;
            r_st_col    <= n_st_col;
            r_end_row   <= n_end_row;
            r_end_col   <= n_end_col;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
            r_rd_ok     <= g_rd_ok && r_grid_vld[g_addr];
            if (g_we) begin
                r_grid_vld[g_addr] <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_code_dn <= n_code_dn;
        r_code_up <= n_code_up;
        r_code_rt <= n_code_rt;
        r_out     <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ src/mbw_checker.sv @@
// Port-level checker for the maze backtrack walker, bound to the top level.
module mbw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input mbw_pkg::t_in_item  i_item,
    input logic               busy,
    input logic               o_valid,
    input mbw_pkg::t_out_item o_result
);

    // a load answers in the very next cycle
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.op == mbw_pkg::OP_LOAD)
            |=> (o_valid && o_result.status == mbw_pkg::STAT_LOADED))
        else $error("load item not answered next cycle");

    // a step occupies the sequencer
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.op == mbw_pkg::OP_STEP) |=> (busy && !o_valid))
        else $error("step item did not raise busy");

    // results only leave once the sequencer is free
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    // a push needs at least two open neighbors and always leads to a move
    a_push_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.pushed)
            |-> (o_result.branch_count > 3'd1
                 && (o_result.status == mbw_pkg::STAT_MOVED
                     || o_result.status == mbw_pkg::STAT_AT_END)))
        else $error("push without a branch");

    // loads carry no branch information
    a_load_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == mbw_pkg::STAT_LOADED)
            |-> (o_result.branch_count == 3'd0 && !o_result.pushed))
        else $error("load result carries branch fields");

endmodule

bind maze_backtrack_walker_top mbw_checker u_mbw_checker (.*);
